@@ hw/rtl/eflt_pkg.sv @@
// ----------------------------------------------------------------------------
// eflt_pkg: shared types, constants and float helpers
// Single-precision constants, sideband struct and round-to-nearest-even
// multiply/add functions used by the exp approximation pipeline.
// ----------------------------------------------------------------------------
package eflt_pkg;

    // Float constants as bit patterns
    localparam logic [31:0] F_L2E  = 32'h3FB8AA3B;
    localparam logic [31:0] F_LN2  = 32'h3F317218;
    localparam logic [31:0] F_P3   = 32'h3D2D7D7D;
    localparam logic [31:0] F_P2   = 32'h3E2AF080;
    localparam logic [31:0] F_P1   = 32'h3EFFF205;
    localparam logic [31:0] F_P0   = 32'h3F80016A;
    localparam logic [31:0] F_ONE  = 32'h3F800000;
    localparam logic [31:0] F_HALF = 32'h3F000000;
    localparam logic [31:0] F_QNAN = 32'h7FC00000;
    localparam logic [31:0] F_PINF = 32'h7F800000;
    localparam logic [31:0] F_ZERO = 32'h00000000;
    // -127.0 magnitude, and biased exponent of 128.0
    localparam logic [30:0] U_LOW_MAG = 31'h42FE0000;
    localparam logic [7:0]  U_HI_EXP  = 8'd134;
    localparam logic [7:0]  EXP_BIAS  = 8'd127;
    localparam logic [7:0]  EXP_MAX   = 8'hFF;

    // Cycles from accepted transaction to result strobe
    localparam int LATENCY = 14;

    // Special-case codes
    localparam logic [1:0] SPEC_NONE = 2'd0;
    localparam logic [1:0] SPEC_NAN  = 2'd1;
    localparam logic [1:0] SPEC_INF  = 2'd2;
    localparam logic [1:0] SPEC_ZERO = 2'd3;

    // Sideband that travels with each item
    typedef struct packed {
        logic [31:0]        x;
        logic [31:0]        r;
        logic signed [7:0]  k;
        logic [1:0]         spec;
    } t_side;

    // Round value m * 2^e (e = weight of m[0], offset so that be = e+174-lz)
    function automatic logic [31:0] f_round(input logic s, input logic signed [11:0] e,
                                            input logic [47:0] m);
        logic [5:0]         lz;
        logic               found;
        logic [47:0]        mn;
        logic signed [12:0] be;
        logic [12:0]        sh;
        logic               st;
        logic               inc;
        logic [30:0]        mag;
        lz    = 6'd0;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found && m[i]) begin
                lz    = 6'(47 - i);
                found = 1'b1;
            end
        end
        mn = m << lz;
        be = $signed({e[11], e}) + 13'sd174 - $signed({7'b0, lz});
        // subnormal: denormalize with sticky collapse
        if (be <= 13'sd0) begin
            sh = 13'(13'sd1 - be);
            if (sh >= 13'd48) begin
                st = |mn;
                mn = 48'd0;
            end else begin
                st = |(mn & ((48'd1 << sh) - 48'd1));
                mn = mn >> sh;
            end
            mn = mn | {47'd0, st};
            be = 13'sd0;
        end
        inc = mn[23] & ((|mn[22:0]) | mn[24]);
        mag = {be[7:0], mn[46:24]} + 31'(inc);
        if (m == 48'd0) begin
            return {s, 31'd0};
        end else if (be >= 13'sd255) begin
            return {s, EXP_MAX, 23'd0};
        end else begin
            return {s, mag};
        end
    endfunction

    // Single-precision multiply, RNE (a NaN or infinite operand gives infinity)
    function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
        logic               s;
        logic [7:0]         xa;
        logic [7:0]         xb;
        logic [47:0]        m;
        logic signed [11:0] e;
        s  = a[31] ^ b[31];
        xa = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        xb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        m  = {24'd0, |a[30:23], a[22:0]} * {24'd0, |b[30:23], b[22:0]};
        e  = $signed({4'd0, xa}) + $signed({4'd0, xb}) - 12'sd300;
        if (a[30:23] == EXP_MAX || b[30:23] == EXP_MAX) begin
            return {s, EXP_MAX, 23'd0};
        end else begin
            return f_round(s, e, m);
        end
    endfunction

    // Single-precision add, RNE (a NaN or infinite operand is returned unchanged)
    function automatic logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0]        big;
        logic [31:0]        sml;
        logic [7:0]         xb;
        logic [7:0]         xs;
        logic [7:0]         d;
        logic [47:0]        mb;
        logic [47:0]        ms0;
        logic [47:0]        ms;
        logic [47:0]        m;
        logic signed [11:0] e;
        if (b[30:0] > a[30:0]) begin
            big = b;
            sml = a;
        end else begin
            big = a;
            sml = b;
        end
        xb  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        xs  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d   = xb - xs;
        mb  = {1'b0, |big[30:23], big[22:0], 23'd0};
        ms0 = {1'b0, |sml[30:23], sml[22:0], 23'd0};
        // align smaller operand, keep shifted-out bits as sticky
        if (d >= 8'd48) begin
            ms = {47'd0, |ms0};
        end else begin
            ms = (ms0 >> d) | {47'd0, |(ms0 & ((48'd1 << d) - 48'd1))};
        end
        m = (big[31] ^ sml[31]) ? (mb - ms) : (mb + ms);
        e = $signed({4'd0, xb}) - 12'sd173;
        if (a[30:23] == EXP_MAX) begin
            return a;
        end else if (b[30:23] == EXP_MAX) begin
            return b;
        end else if (m == 48'd0) begin
            return {a[31] & b[31], 31'd0};
        end else begin
            return f_round(big[31], e, m);
        end
    endfunction

endpackage

@@ hw/rtl/exp_float32_approx_unit.sv @@
// ----------------------------------------------------------------------------
// exp_float32_approx_unit: pipelined single-precision exp(x) approximation
// Range reduction by k = round(x*log2e), cubic polynomial on r = x - k*ln2,
// then scaling by 2^k. One float operation per pipeline stage.
// ----------------------------------------------------------------------------
//  channel   | direction | signals                        | handshake
//  ----------+-----------+--------------------------------+-------------------
//  command   | in        | i_x_bits                       | start & !busy
//  result    | out       | o_y_bits, o_range_flag         | o_valid strobe
//
//  Fourteen register stages: thirteen with one float multiply or add each,
//  and one that truncates u to k and converts k back to float.
//  The result strobe is the valid bit of the last stage.
//  A new transaction is taken every cycle; busy stays low.
//  Synchronous active-low reset clears all stage valid bits.
//  The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module exp_float32_approx_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_x_bits,
    output logic        o_valid,
    output logic [31:0] o_y_bits,
    output logic        o_range_flag
);

    logic            w_v  [1:14];
    logic [31:0]     w_z  [1:14];
    eflt_pkg::t_side w_sd [1:14];

    eflt_pkg::t_side w_sd0;
    eflt_pkg::t_side w_sd5r;
    logic [31:0]     w_half;
    logic [31:0]     w_negm;
    logic [31:0]     w_pow2;
    logic [7:0]      w_ebias;

    // input sideband, NaN/infinite input flagged up front
    always_comb begin
        w_sd0      = '0;
        w_sd0.x    = i_x_bits;
        w_sd0.spec = (i_x_bits[30:23] == eflt_pkg::EXP_MAX) ? eflt_pkg::SPEC_NAN
                                                            : eflt_pkg::SPEC_NONE;
    end

    // t = x * log2e
    eflt_mul_stg u_s1 (.i_clk, .i_rst_n, .i_valid(start), .i_a(i_x_bits),
        .i_b(eflt_pkg::F_L2E), .i_side(w_sd0),
        .o_valid(w_v[1]), .o_z(w_z[1]), .o_side(w_sd[1]));

    // u = t +/- 0.5, sign from x (-0 counts as nonnegative)
    assign w_half = (w_sd[1].x[31] && (w_sd[1].x[30:0] != 31'd0))
                  ? {1'b1, eflt_pkg::F_HALF[30:0]} : eflt_pkg::F_HALF;

    eflt_add_stg u_s2 (.i_clk, .i_rst_n, .i_valid(w_v[1]), .i_a(w_z[1]),
        .i_b(w_half), .i_side(w_sd[1]),
        .o_valid(w_v[2]), .o_z(w_z[2]), .o_side(w_sd[2]));

    // k and float(k)
    eflt_red_stg u_s3 (.i_clk, .i_rst_n, .i_valid(w_v[2]), .i_u(w_z[2]),
        .i_side(w_sd[2]),
        .o_valid(w_v[3]), .o_kf(w_z[3]), .o_side(w_sd[3]));

    // m = kf * ln2
    eflt_mul_stg u_s4 (.i_clk, .i_rst_n, .i_valid(w_v[3]), .i_a(w_z[3]),
        .i_b(eflt_pkg::F_LN2), .i_side(w_sd[3]),
        .o_valid(w_v[4]), .o_z(w_z[4]), .o_side(w_sd[4]));

    // r = x - m
    assign w_negm = {~w_z[4][31], w_z[4][30:0]};

    eflt_add_stg u_s5 (.i_clk, .i_rst_n, .i_valid(w_v[4]), .i_a(w_sd[4].x),
        .i_b(w_negm), .i_side(w_sd[4]),
        .o_valid(w_v[5]), .o_z(w_z[5]), .o_side(w_sd[5]));

    // keep r in the sideband for the Horner steps
    always_comb begin
        w_sd5r   = w_sd[5];
        w_sd5r.r = w_z[5];
    end

    // Horner: ((P3*r + P2)*r + P1)*r + P0
    eflt_mul_stg u_s6 (.i_clk, .i_rst_n, .i_valid(w_v[5]), .i_a(eflt_pkg::F_P3),
        .i_b(w_z[5]), .i_side(w_sd5r),
        .o_valid(w_v[6]), .o_z(w_z[6]), .o_side(w_sd[6]));

    eflt_add_stg u_s7 (.i_clk, .i_rst_n, .i_valid(w_v[6]), .i_a(w_z[6]),
        .i_b(eflt_pkg::F_P2), .i_side(w_sd[6]),
        .o_valid(w_v[7]), .o_z(w_z[7]), .o_side(w_sd[7]));

    eflt_mul_stg u_s8 (.i_clk, .i_rst_n, .i_valid(w_v[7]), .i_a(w_z[7]),
        .i_b(w_sd[7].r), .i_side(w_sd[7]),
        .o_valid(w_v[8]), .o_z(w_z[8]), .o_side(w_sd[8]));

    eflt_add_stg u_s9 (.i_clk, .i_rst_n, .i_valid(w_v[8]), .i_a(w_z[8]),
        .i_b(eflt_pkg::F_P1), .i_side(w_sd[8]),
        .o_valid(w_v[9]), .o_z(w_z[9]), .o_side(w_sd[9]));

    eflt_mul_stg u_s10 (.i_clk, .i_rst_n, .i_valid(w_v[9]), .i_a(w_z[9]),
        .i_b(w_sd[9].r), .i_side(w_sd[9]),
        .o_valid(w_v[10]), .o_z(w_z[10]), .o_side(w_sd[10]));

    eflt_add_stg u_s11 (.i_clk, .i_rst_n, .i_valid(w_v[10]), .i_a(w_z[10]),
        .i_b(eflt_pkg::F_P0), .i_side(w_sd[10]),
        .o_valid(w_v[11]), .o_z(w_z[11]), .o_side(w_sd[11]));

    // q = r * p
    eflt_mul_stg u_s12 (.i_clk, .i_rst_n, .i_valid(w_v[11]), .i_a(w_sd[11].r),
        .i_b(w_z[11]), .i_side(w_sd[11]),
        .o_valid(w_v[12]), .o_z(w_z[12]), .o_side(w_sd[12]));

    // s = 1 + q
    eflt_add_stg u_s13 (.i_clk, .i_rst_n, .i_valid(w_v[12]), .i_a(eflt_pkg::F_ONE),
        .i_b(w_z[12]), .i_side(w_sd[12]),
        .o_valid(w_v[13]), .o_z(w_z[13]), .o_side(w_sd[13]));

    // 2^k from the exponent field
    assign w_ebias = w_sd[13].k + eflt_pkg::EXP_BIAS;
    assign w_pow2  = {1'b0, w_ebias, 23'd0};

    eflt_mul_stg u_s14 (.i_clk, .i_rst_n, .i_valid(w_v[13]), .i_a(w_pow2),
        .i_b(w_z[13]), .i_side(w_sd[13]),
        .o_valid(w_v[14]), .o_z(w_z[14]), .o_side(w_sd[14]));

    // result select
    always_comb begin
        case (w_sd[14].spec)
            eflt_pkg::SPEC_NAN:  o_y_bits = eflt_pkg::F_QNAN;
            eflt_pkg::SPEC_INF:  o_y_bits = eflt_pkg::F_PINF;
            eflt_pkg::SPEC_ZERO: o_y_bits = eflt_pkg::F_ZERO;
            default:             o_y_bits = w_z[14];
        endcase
    end

    assign o_range_flag = (w_sd[14].spec != eflt_pkg::SPEC_NONE);
    assign o_valid      = w_v[14];
    assign busy         = 1'b0;

endmodule

@@ hw/rtl/eflt_mul_stg.sv @@
// ----------------------------------------------------------------------------
// eflt_mul_stg: one registered float multiply stage
// Computes a*b in single precision, RNE, and forwards valid and sideband.
// ----------------------------------------------------------------------------
module eflt_mul_stg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [31:0]         i_a,
    input  logic [31:0]         i_b,
    input  eflt_pkg::t_side     i_side,
    output logic                o_valid,
    output logic [31:0]         o_z,
    output eflt_pkg::t_side     o_side
);

    logic            r_valid;
    logic [31:0]     r_z;
    eflt_pkg::t_side r_side;
    logic [31:0]     n_z;

    // product
    assign n_z = eflt_pkg::f_mul(i_a, i_b);

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_z    <= n_z;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

@@ hw/rtl/eflt_add_stg.sv @@
// ----------------------------------------------------------------------------
// eflt_add_stg: one registered float add stage
// Computes a+b in single precision, RNE, and forwards valid and sideband.
// ----------------------------------------------------------------------------
module eflt_add_stg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [31:0]         i_a,
    input  logic [31:0]         i_b,
    input  eflt_pkg::t_side     i_side,
    output logic                o_valid,
    output logic [31:0]         o_z,
    output eflt_pkg::t_side     o_side
);

    logic            r_valid;
    logic [31:0]     r_z;
    eflt_pkg::t_side r_side;
    logic [31:0]     n_z;

    // sum
    assign n_z = eflt_pkg::f_add(i_a, i_b);

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_z    <= n_z;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

@@ hw/rtl/eflt_red_stg.sv @@
// ----------------------------------------------------------------------------
// eflt_red_stg: range reduction decode stage
// Truncates u to integer k, converts k back to float, and flags k out of
// range (overflow to infinity, underflow to zero).
// ----------------------------------------------------------------------------
module eflt_red_stg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [31:0]         i_u,
    input  eflt_pkg::t_side     i_side,
    output logic                o_valid,
    output logic [31:0]         o_kf,
    output eflt_pkg::t_side     o_side
);

    logic              r_valid;
    logic [31:0]       r_kf;
    eflt_pkg::t_side   r_side;
    logic [7:0]        w_mag;
    logic [7:0]        w_sh;
    logic signed [7:0] w_k;
    logic              w_hi;
    logic              w_lo;
    eflt_pkg::t_side   n_side;
    logic [31:0]       n_kf;

    // truncate toward zero; |u| < 128 on the in-range path
    always_comb begin
        w_sh  = 8'd150 - i_u[30:23];
        w_mag = (i_u[30:23] < eflt_pkg::EXP_BIAS) ? 8'd0
              : 8'(({1'b1, i_u[22:0]}) >> w_sh);
        w_k   = i_u[31] ? -$signed(w_mag) : $signed(w_mag);
    end

    // range checks on u
    assign w_hi = !i_u[31] && (i_u[30:23] >= eflt_pkg::U_HI_EXP);
    assign w_lo = i_u[31] && (i_u[30:0] >= eflt_pkg::U_LOW_MAG);

    // k back to float (exact)
    assign n_kf = eflt_pkg::f_round(i_u[31], 12'sd0, {40'd0, w_mag});

    always_comb begin
        n_side   = i_side;
        n_side.k = w_k;
        if (i_side.spec == eflt_pkg::SPEC_NONE) begin
            if (w_hi) begin
                n_side.spec = eflt_pkg::SPEC_INF;
            end else if (w_lo) begin
                n_side.spec = eflt_pkg::SPEC_ZERO;
            end
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_kf   <= n_kf;
        r_side <= n_side;
    end

    assign o_valid = r_valid;
    assign o_kf    = r_kf;
    assign o_side  = r_side;

endmodule

@@ hw/rtl/eflt_chk.sv @@
// ----------------------------------------------------------------------------
// eflt_chk: port-level checker for exp_float32_approx_unit
// Watches the command and result ports for latency and special-case rules.
// ----------------------------------------------------------------------------
module eflt_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [31:0] i_x_bits,
    input logic        o_valid,
    input logic [31:0] o_y_bits,
    input logic        o_range_flag
);

    // every accepted transaction gives a result after the pipeline depth
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(eflt_pkg::LATENCY) o_valid)
        else $error("result strobe missing after accepted transaction");

    // no result without a transaction accepted one latency earlier
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, eflt_pkg::LATENCY))
        else $error("result strobe without matching transaction");

    // NaN or infinite operand gives flagged quiet NaN
    a_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_x_bits[30:23] == eflt_pkg::EXP_MAX))
        |-> ##(eflt_pkg::LATENCY)
        (o_range_flag && (o_y_bits == eflt_pkg::F_QNAN)))
        else $error("special operand not mapped to flagged NaN");

    // an unflagged result is always finite
    a_finite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_range_flag) |-> (o_y_bits[30:23] != eflt_pkg::EXP_MAX))
        else $error("unflagged result is not finite");

endmodule

bind exp_float32_approx_unit eflt_chk u_eflt_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_x_bits     (i_x_bits),
    .o_valid      (o_valid),
    .o_y_bits     (o_y_bits),
    .o_range_flag (o_range_flag)
);

@@ tb/sv/exp_float32_approx_checker.sv @@
// ----------------------------------------------------------------------------
// exp_float32_approx_checker: result predictor and scoreboard
// Watches the command and result channels of the exp approximation unit,
// predicts each result with a bit-exact single-precision model of its own
// and compares it field by field with what the unit returns.
// ----------------------------------------------------------------------------
module exp_float32_approx_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [31:0] i_x_bits,
    input  logic        i_valid,
    input  logic [31:0] i_y_bits,
    input  logic        i_range_flag,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked,
    output int          o_flagged
);
    timeunit 1ns;
    timeprecision 1ps;

    // Float constants as bit patterns
    localparam logic [31:0] LOG2E_F = 32'h3FB8AA3B;
    localparam logic [31:0] LN2_F   = 32'h3F317218;
    localparam logic [31:0] C3_F    = 32'h3D2D7D7D;
    localparam logic [31:0] C2_F    = 32'h3E2AF080;
    localparam logic [31:0] C1_F    = 32'h3EFFF205;
    localparam logic [31:0] C0_F    = 32'h3F80016A;
    localparam logic [31:0] ONE_F   = 32'h3F800000;
    localparam logic [31:0] HALF_F  = 32'h3F000000;
    localparam logic [31:0] QNAN_F  = 32'h7FC00000;
    localparam logic [31:0] PINF_F  = 32'h7F800000;
    localparam logic [30:0] MAG_128 = 31'h43000000;
    localparam logic [30:0] MAG_127 = 31'h42FE0000;

    typedef logic [319:0] t_wide;

    typedef struct {
        logic [31:0] y;
        logic        flag;
    } t_exp_result;

    t_exp_result exp_expected_q[$];

    // Round exact value (-1)^s * m * 2^e to single, nearest even
    function automatic logic [31:0] fp_pack(input logic s, input int e, input t_wide m);
        int    p;
        int    sh;
        int    be;
        bit    found;
        t_wide q;
        t_wide rem;
        t_wide half;
        if (m == '0) return {s, 31'd0};
        p = 0;
        found = 0;
        for (int i = 319; i >= 0; i--) begin
            if (!found && m[i]) begin
                p = i;
                found = 1;
            end
        end
        sh = p - 23;
        if (sh < -149 - e) sh = -149 - e;
        if (sh > 0) begin
            q    = m >> sh;
            rem  = m & ((t_wide'(1) << sh) - t_wide'(1));
            half = t_wide'(1) << (sh - 1);
            if (rem > half || (rem == half && q[0])) q = q + t_wide'(1);
        end else begin
            q = m << (-sh);
        end
        if (q[24]) begin
            q  = q >> 1;
            sh = sh + 1;
        end
        if (!q[23]) return {s, 8'd0, q[22:0]};
        be = e + sh + 150;
        if (be >= 255) return {s, 8'hFF, 23'd0};
        return {s, be[7:0], q[22:0]};
    endfunction

    // Split a finite float into integer significand and lsb weight
    function automatic void fp_split(input logic [31:0] a, output int e, output t_wide m);
        if (a[30:23] == 8'd0) begin
            e = -149;
            m = t_wide'(a[22:0]);
        end else begin
            e = int'(a[30:23]) - 150;
            m = t_wide'({1'b1, a[22:0]});
        end
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        int    ea;
        int    eb;
        t_wide ma;
        t_wide mb;
        fp_split(a, ea, ma);
        fp_split(b, eb, mb);
        return fp_pack(a[31] ^ b[31], ea + eb, ma * mb);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        int    ea;
        int    eb;
        int    em;
        t_wide ma;
        t_wide mb;
        if (a[30:23] == 8'hFF) return a;
        if (b[30:23] == 8'hFF) return b;
        fp_split(a, ea, ma);
        fp_split(b, eb, mb);
        em = (ea < eb) ? ea : eb;
        ma = ma << (ea - em);
        mb = mb << (eb - em);
        if (a[31] == b[31]) return fp_pack(a[31], em, ma + mb);
        if (ma == mb) return {a[31] & b[31], 31'd0};
        if (ma > mb) return fp_pack(a[31], em, ma - mb);
        return fp_pack(b[31], em, mb - ma);
    endfunction

    // Expected exp(x) approximation for one operand
    function automatic t_exp_result exp_predict(input logic [31:0] x);
        t_exp_result res;
        logic [31:0] t;
        logic [31:0] u;
        logic [31:0] kf;
        logic [31:0] r;
        logic [31:0] p;
        logic [31:0] s;
        logic [31:0] scale;
        logic [23:0] kmag;
        int          k;
        res.flag = 1'b1;
        if (x[30:23] == 8'hFF) begin
            res.y = QNAN_F;
            return res;
        end
        t = fp_mul(x, LOG2E_F);
        // round half away from zero; -0 takes the positive branch
        if (!x[31] || x[30:0] == 31'd0) u = fp_add(t, HALF_F);
        else u = fp_add(t, {1'b1, HALF_F[30:0]});
        if (!u[31] && u[30:0] >= MAG_128) begin
            res.y = PINF_F;
            return res;
        end
        if (u[31] && u[30:0] >= MAG_127) begin
            res.y = 32'd0;
            return res;
        end
        // truncate toward zero
        if (u[30:23] < 8'd127) kmag = 24'd0;
        else kmag = {1'b1, u[22:0]} >> (150 - int'(u[30:23]));
        k  = u[31] ? -int'(kmag) : int'(kmag);
        kf = fp_pack(u[31] && kmag != 0, 0, t_wide'(kmag));
        r  = fp_add(x, {1'b1, 31'd0} ^ fp_mul(kf, LN2_F));
        p  = fp_add(fp_mul(C3_F, r), C2_F);
        p  = fp_add(fp_mul(p, r), C1_F);
        p  = fp_add(fp_mul(p, r), C0_F);
        s  = fp_add(ONE_F, fp_mul(r, p));
        scale = {1'b0, 8'(k + 127), 23'd0};
        res.y    = fp_mul(scale, s);
        res.flag = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
        o_flagged = 0;
    end

    // Predict on each accepted command transaction, compare on each strobe
    always @(posedge i_clk) begin
        t_exp_result want;
        if (i_rst_n) begin
            if (i_start && !i_busy) exp_expected_q.push_back(exp_predict(i_x_bits));
            if (i_valid) begin
                if (exp_expected_q.size() == 0) begin
                    report_mismatch("unexpected result", i_y_bits, 32'd0);
                end else begin
                    want = exp_expected_q.pop_front();
                    if (i_y_bits !== want.y) report_mismatch("y_bits", i_y_bits, want.y);
                    if (i_range_flag !== want.flag)
                        report_mismatch("range_flag", 32'(i_range_flag), 32'(want.flag));
                    o_checked++;
                    if (want.flag) o_flagged++;
                end
            end
        end
        o_pending = exp_expected_q.size();
    end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: top level testbench for exp_float32_approx_unit
// Drives directed edge operands and then random operands weighted toward the
// useful exp range, with random sender gaps; the checker scores results.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LATENCY = 14;
    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_x_bits;
    logic        o_valid;
    logic [31:0] o_y_bits;
    logic        o_range_flag;
    int          errors;
    int          pending;
    int          checked;
    int          flagged;
    int          cycles;
    int          sent;

    exp_float32_approx_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_x_bits    (i_x_bits),
        .o_valid     (o_valid),
        .o_y_bits    (o_y_bits),
        .o_range_flag(o_range_flag)
    );

    exp_float32_approx_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_x_bits    (i_x_bits),
        .i_valid     (o_valid),
        .i_y_bits    (o_y_bits),
        .i_range_flag(o_range_flag),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_flagged   (flagged)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // One command transaction, then an optional gap
    task automatic send_x(input logic [31:0] x, input int gap);
        start    <= 1'b1;
        i_x_bits <= x;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Random operand, mostly inside the interesting exponent window
    function automatic logic [31:0] rand_operand();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) return $urandom();
        if (sel < 8) return {1'($urandom()), 8'($urandom_range(110, 134)), 23'($urandom())};
        return {1'($urandom()), 8'($urandom_range(0, 150)), 23'($urandom())};
    endfunction

    logic [31:0] directed_ops[] = '{
        32'h00000000, 32'h80000000, 32'h7FC00000, 32'h7F800001, 32'hFFFFFFFF,
        32'h7F800000, 32'hFF800000, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h00000001,
        32'h80000001, 32'h3F800000, 32'hBF800000, 32'h42B17218, 32'h42B20000,
        32'hC2AEAC50, 32'hC2B00000, 32'hC2CE0000, 32'h3F000000, 32'hBF000000,
        32'h42FE0000, 32'h3EB17218, 32'hBEB17218, 32'h007FFFFF, 32'h3A000000
    };

    int burst_mode;

    initial begin
        start    = 1'b0;
        i_x_bits = 32'd0;
        i_rst_n  = 1'b0;
        sent     = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed edge operands
        foreach (directed_ops[i]) send_x(directed_ops[i], $urandom_range(0, 2));

        // random operands; gap style is drawn anew every 40 transactions
        burst_mode = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) burst_mode = $urandom_range(0, 2);
            if (n == RANDOM_ITEMS / 2) begin
                // drain the pipeline before continuing
                start <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            send_x(rand_operand(), (burst_mode == 0) ? 0 :
                   (burst_mode == 1) ? $urandom_range(0, 18) : $urandom_range(0, 2));
        end
        start <= 1'b0;

        // drain and settle
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);

        $display("Sent %0d operands; %0d results checked, %0d with the range flag set.",
                 sent, checked, flagged);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
